[rtl/lsfp_pkg.sv]
// shared constants, types and the descriptor table for the scan frame parser
package lsfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ANGLE_W  = 15;
    localparam int unsigned DIST_W   = 16;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE      = 8'h3E;
    localparam logic [POS_W-1:0]   DESC_LAST_POS  = 3'd6;
    localparam logic [POS_W-1:0]   DESC_LEN       = 3'd7;
    localparam logic [POS_W-1:0]   FRAME_HUNT     = 3'd0;
    localparam logic [POS_W-1:0]   FRAME_LAST_POS = 3'd4;

    localparam logic [ANGLE_W-1:0] WRAP_LIMIT_Q6  = 15'd2880;
    localparam logic [ANGLE_W-1:0] WRAP_FROM_Q6   = 15'd20160;
    localparam logic [ANGLE_W-1:0] WRAP_TO_Q6     = 15'd23040;
    localparam logic [ANGLE_W-1:0] WINDOW_LOW_RST  = 15'd0;
    localparam logic [ANGLE_W-1:0] WINDOW_HIGH_RST = 15'd23039;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LOW  = 1'b0;
    localparam logic REG_WINDOW_HIGH = 1'b1;

    localparam logic KIND_DESCRIPTOR  = 1'b0;
    localparam logic KIND_MEASUREMENT = 1'b1;

    typedef struct packed {
        logic               emit;
        logic               kind;
        logic               descriptor_ok;
        logic [ANGLE_W-1:0] angle_q6;
        logic [DIST_W-1:0]  distance_q2;
    } result_t;

    // expected scan response descriptor bytes
    function automatic logic [BYTE_W-1:0] desc_byte(input logic [POS_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = 8'hA5;
            3'd1:    b = 8'h5A;
            3'd2:    b = 8'h05;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h40;
            3'd6:    b = 8'h81;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/lidar_scan_frame_parser_top.sv]
// top level of the scan frame parser: stream ports, register port, pipeline registers
//
//  channel   dir  tdata / data                                    side band
//  s_*       in   [7:0] rx_byte                                   tuser: restart
//  m_*       out  [0] descriptor_ok [15:1] angle_q6 [31:16] distance_q2  tuser: result_kind
//  apb       in   0x0 window_low_q6, 0x4 window_high_q6 (15 bit)  pready tied high
//
//  one byte is accepted per cycle while the input register is not stalled; a byte's result
//  is loaded into the result register when that byte advances out of the input register
//  rst_n clears positions, flags, valid bits and restores the window registers
//  a held result stalls the input register only if the next byte yields a result
module lidar_scan_frame_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  logic                          s_tuser,   // [0] restart
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [0] descriptor_ok, [15:1] angle_q6, [31:16] distance_q2
    output logic                          m_tuser,   // [0] result_kind
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsfp_pkg::ADDR_W-1:0]   paddr,
    input  logic [lsfp_pkg::DATA_W-1:0]   pwdata,
    output logic [lsfp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import lsfp_pkg::*;

    logic [ANGLE_W-1:0] window_low_reg;
    logic [ANGLE_W-1:0] window_high_reg;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_restart_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic               out_ok_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic [DIST_W-1:0]  out_dist_reg;

    result_t            result;
    logic               out_free;
    logic               advance;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_WINDOW_HIGH)
                     ? {{(DATA_W-ANGLE_W){1'b0}}, window_high_reg}
                     : {{(DATA_W-ANGLE_W){1'b0}}, window_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= WINDOW_LOW_RST;
            window_high_reg <= WINDOW_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW_LOW:  window_low_reg  <= pwdata[ANGLE_W-1:0];
                REG_WINDOW_HIGH: window_high_reg <= pwdata[ANGLE_W-1:0];
                default:         window_low_reg  <= window_low_reg;
            endcase
        end
    end

    lsfp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .restart        (in_restart_reg),
        .window_low_q6  (window_low_reg),
        .window_high_q6 (window_high_reg),
        .result         (result)
    );

    // a byte without a result never waits for the output side
    assign out_free = ~out_valid_reg | m_tready;
    assign advance  = in_valid_reg & (out_free | ~result.emit);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && result.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_kind_reg  <= result.kind;
            out_ok_reg    <= result.descriptor_ok;
            out_angle_reg <= result.angle_q6;
            out_dist_reg  <= result.distance_q2;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_dist_reg, out_angle_reg, out_ok_reg};

endmodule

[rtl/lsfp_core.sv]
// parse state: descriptor check, sync hunt, payload collection and window test
module lsfp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lsfp_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          restart,
    input  logic [lsfp_pkg::ANGLE_W-1:0]  window_low_q6,
    input  logic [lsfp_pkg::ANGLE_W-1:0]  window_high_q6,
    output lsfp_pkg::result_t             result
);
    import lsfp_pkg::*;

    logic [POS_W-1:0]  desc_pos_reg, desc_pos_next;
    logic              mismatch_reg, mismatch_next;
    logic [POS_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [BYTE_W-1:0] payload_reg [3];

    logic [POS_W-1:0]  desc_pos_eff;
    logic              mismatch_eff;
    logic [POS_W-1:0]  frame_pos_eff;
    logic [POS_W-1:0]  frame_idx;
    logic              payload_we;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
    logic              has_sync;
    logic              in_window;

    assign desc_pos_eff  = restart ? '0 : desc_pos_reg;
    assign mismatch_eff  = restart ? 1'b0 : mismatch_reg;
    assign frame_pos_eff = restart ? FRAME_HUNT : frame_pos_reg;
    assign frame_idx     = frame_pos_eff - 3'd1;

    // last payload byte is used straight from the input
    assign angle    = {payload_reg[1], payload_reg[0][BYTE_W-1:1]};
    assign distance = {rx_byte, payload_reg[2]};
    assign has_sync = (payload_reg[0] == SYNC_BYTE) || (payload_reg[1] == SYNC_BYTE)
                   || (payload_reg[2] == SYNC_BYTE) || (rx_byte == SYNC_BYTE);
    assign in_window = ((angle >= window_low_q6) && (angle <= window_high_q6))
                    || ((window_high_q6 <= WRAP_LIMIT_Q6) && (angle >= WRAP_FROM_Q6)
                        && (angle < WRAP_TO_Q6));

    always_comb
    begin
        desc_pos_next  = desc_pos_eff;
        mismatch_next  = mismatch_eff;
        frame_pos_next = frame_pos_eff;
        payload_we     = 1'b0;
        result         = '0;
        if (desc_pos_eff < DESC_LEN)
        begin
            mismatch_next = mismatch_eff | (rx_byte != desc_byte(desc_pos_eff));
            desc_pos_next = desc_pos_eff + 3'd1;
            if (desc_pos_eff == DESC_LAST_POS)
            begin
                result.emit          = 1'b1;
                result.kind          = KIND_DESCRIPTOR;
                result.descriptor_ok = ~mismatch_next;
            end
        end
        else if (!mismatch_eff)
        begin
            if (frame_pos_eff == FRAME_HUNT)
            begin
                if (rx_byte == SYNC_BYTE)
                    frame_pos_next = 3'd1;
            end
            else if (frame_pos_eff < FRAME_LAST_POS)
            begin
                payload_we     = 1'b1;
                frame_pos_next = frame_pos_eff + 3'd1;
            end
            else
            begin
                frame_pos_next = FRAME_HUNT;
                if ((distance != '0) && !has_sync && in_window)
                begin
                    result.emit        = 1'b1;
                    result.kind        = KIND_MEASUREMENT;
                    result.angle_q6    = angle;
                    result.distance_q2 = distance;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_pos_reg  <= '0;
            mismatch_reg  <= 1'b0;
            frame_pos_reg <= FRAME_HUNT;
        end
        else if (step)
        begin
            desc_pos_reg  <= desc_pos_next;
            mismatch_reg  <= mismatch_next;
            frame_pos_reg <= frame_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && payload_we)
            payload_reg[frame_idx[1:0]] <= rx_byte;
    end

endmodule

[sim/lidar_scan_frame_parser_top_test.sv]
// self-checking testbench for the scan frame parser: directed table, random frames, window settings
module lidar_scan_frame_parser_top_test;

    import lsfp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned PHASE_BYTES    = 75;
    localparam int unsigned PRINT_LIMIT    = 40;

    typedef struct packed {
        logic               kind;
        logic               ok;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
    } scan_result_t;

    typedef enum logic [1:0] {
        ROW_MODEL,   // result taken from the predictor
        ROW_RESULT,  // result typed in the row
        ROW_DROP     // no result may come
    } row_check_e;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              restart;
        row_check_e        check;
        scan_result_t      res;
    } stim_row_t;

    localparam scan_result_t NO_RESULT = '0;
    localparam logic [BYTE_W-1:0] DESC_TABLE [7] =
        '{8'hA5, 8'h5A, 8'h05, 8'h00, 8'h00, 8'h40, 8'h81};

    localparam int unsigned N_ROWS = 30;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'hA5, 1'b1, ROW_MODEL,  NO_RESULT},
        '{8'h5A, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h05, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h40, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h81, 1'b0, ROW_RESULT, '{KIND_DESCRIPTOR, 1'b1, 15'd0, 16'd0}},
        // largest angle in range with largest distance
        '{8'h3E, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'hFE, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'hB3, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'hFF, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'hFF, 1'b0, ROW_RESULT, '{KIND_MEASUREMENT, 1'b0, WINDOW_HIGH_RST, 16'hFFFF}},
        // zero distance is dropped
        '{8'h3E, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_DROP,   NO_RESULT},
        // sync value inside the payload is collected, frame dropped
        '{8'h3E, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h3E, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h10, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h20, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h30, 1'b0, ROW_DROP,   NO_RESULT},
        // bad descriptor, then everything ignored
        '{8'hA5, 1'b1, ROW_MODEL,  NO_RESULT},
        '{8'h5A, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h05, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h00, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h40, 1'b0, ROW_MODEL,  NO_RESULT},
        '{8'h80, 1'b0, ROW_RESULT, '{KIND_DESCRIPTOR, 1'b0, 15'd0, 16'd0}},
        '{8'h3E, 1'b0, ROW_DROP,   NO_RESULT}
    };

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;   // [7:0] rx_byte
    logic                s_tuser  = 1'b0; // [0] restart
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;         // [0] descriptor_ok, [15:1] angle_q6, [31:16] distance_q2
    logic                m_tuser;         // [0] result_kind
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lidar_scan_frame_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state as predicted
    logic [ANGLE_W-1:0] win_lo = WINDOW_LOW_RST;
    logic [ANGLE_W-1:0] win_hi = WINDOW_HIGH_RST;
    logic [POS_W-1:0]   desc_pos   = '0;
    logic               desc_bad   = 1'b0;
    logic [POS_W-1:0]   frame_pos  = FRAME_HUNT;
    logic [BYTE_W-1:0]  payload [4];

    scan_result_t scan_results_due [$];
    int unsigned  errors     = 0;
    int unsigned  burst_left = 0;
    int unsigned  bytes_sent = 0;
    bit           hold_req   = 1'b0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < PRINT_LIMIT)
            $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
        errors++;
    endtask

    function automatic logic window_accepts(input logic [ANGLE_W-1:0] ang);
        if (ang >= win_lo && ang <= win_hi)
            return 1'b1;
        return win_hi <= WRAP_LIMIT_Q6 && ang >= WRAP_FROM_Q6 && ang < WRAP_TO_Q6;
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] rx, input logic restart,
                                       output logic got, output scan_result_t res);
        logic [ANGLE_W-1:0] ang;
        logic [DIST_W-1:0]  distance;
        logic               lost;
        got = 1'b0;
        res = NO_RESULT;
        if (restart)
        begin
            desc_pos  = '0;
            desc_bad  = 1'b0;
            frame_pos = FRAME_HUNT;
        end
        if (desc_pos < DESC_LEN)
        begin
            if (rx != DESC_TABLE[desc_pos])
                desc_bad = 1'b1;
            desc_pos++;
            if (desc_pos == DESC_LEN)
            begin
                got = 1'b1;
                res = '{KIND_DESCRIPTOR, !desc_bad, '0, '0};
            end
            return;
        end
        if (desc_bad)
            return;
        if (frame_pos == FRAME_HUNT)
        begin
            if (rx == SYNC_BYTE)
                frame_pos = 3'd1;
            return;
        end
        payload[frame_pos - 3'd1] = rx;
        if (frame_pos < FRAME_LAST_POS)
        begin
            frame_pos++;
            return;
        end
        frame_pos = FRAME_HUNT;
        ang      = {payload[1], payload[0][7:1]};
        distance = {payload[3], payload[2]};
        lost = payload[0] == SYNC_BYTE || payload[1] == SYNC_BYTE ||
               payload[2] == SYNC_BYTE || payload[3] == SYNC_BYTE;
        if (distance == '0 || lost || !window_accepts(ang))
            return;
        got = 1'b1;
        res = '{KIND_MEASUREMENT, 1'b0, ang, distance};
    endfunction

    // one byte transfer; sender runs in bursts with random gaps
    task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic restart,
                             input row_check_e check, input scan_result_t typed);
        int unsigned  gap;
        logic         got;
        scan_result_t res;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = rx;
        s_tuser  = restart;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        parse_byte(rx, restart, got, res);
        case (check)
            ROW_MODEL:  if (got) scan_results_due.push_back(res);
            ROW_RESULT: scan_results_due.push_back(typed);
            default:    ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic reg_idx, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {reg_idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_window();
        logic [DATA_W-1:0] rd;
        apb_access(1'b0, REG_WINDOW_LOW, '0, rd);
        if (rd != {17'd0, win_lo})
            report_mismatch("window_low_q6 readback", rd, win_lo);
        apb_access(1'b0, REG_WINDOW_HIGH, '0, rd);
        if (rd != {17'd0, win_hi})
            report_mismatch("window_high_q6 readback", rd, win_hi);
    endtask

    // upper data bits carry junk, the register keeps 15 bits
    task automatic set_window(input logic [ANGLE_W-1:0] lo, input logic [ANGLE_W-1:0] hi);
        logic [DATA_W-1:0] junk;
        logic [DATA_W-1:0] rd;
        junk = $urandom();
        apb_access(1'b1, REG_WINDOW_LOW, {junk[31:15], lo}, rd);
        win_lo = lo;
        junk = $urandom();
        apb_access(1'b1, REG_WINDOW_HIGH, {junk[31:15], hi}, rd);
        win_hi = hi;
        check_window();
    endtask

    task automatic send_descriptor(input bit corrupt);
        int unsigned       bad_idx;
        logic [BYTE_W-1:0] rx;
        bad_idx = corrupt ? $urandom_range(0, 6) : 7;
        for (int i = 0; i < 7; i++)
        begin
            rx = DESC_TABLE[i];
            if (i == bad_idx)
                rx = rx ^ 8'($urandom_range(1, 255));
            send_byte(rx, i == 0, ROW_MODEL, NO_RESULT);
        end
    endtask

    task automatic send_frame();
        logic [ANGLE_W-1:0] ang;
        logic [DIST_W-1:0]  distance;
        logic [BYTE_W-1:0]  pay [4];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ang = (win_lo <= win_hi) ? 15'($urandom_range(win_lo, win_hi))
                                                     : 15'($urandom());
            5, 6:          ang = 15'($urandom_range(WRAP_FROM_Q6, WRAP_TO_Q6 - 1));
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       ang = win_lo;
                    1:       ang = win_hi;
                    2:       ang = win_hi + 15'd1;
                    3:       ang = WRAP_FROM_Q6 - 15'd1;
                    4:       ang = WRAP_TO_Q6 - 15'd1;
                    default: ang = WRAP_TO_Q6;
                endcase
            end
            default:       ang = 15'($urandom());
        endcase
        case ($urandom_range(0, 11))
            0:       distance = '0;
            1:       distance = 16'hFFFF;
            default: distance = 16'($urandom());
        endcase
        pay[0] = {ang[6:0], 1'($urandom())};
        pay[1] = ang[14:7];
        pay[2] = distance[7:0];
        pay[3] = distance[15:8];
        if ($urandom_range(0, 11) == 0)
            pay[$urandom_range(0, 3)] = SYNC_BYTE;
        send_byte(SYNC_BYTE, 1'b0, ROW_MODEL, NO_RESULT);
        for (int i = 0; i < 4; i++)
            send_byte(pay[i], 1'b0, ROW_MODEL, NO_RESULT);
    endtask

    task automatic run_phase(input logic [ANGLE_W-1:0] lo, input logic [ANGLE_W-1:0] hi,
                             input bit pressure);
        int unsigned start;
        int unsigned pick;
        wait_idle();
        set_window(lo, hi);
        if (pressure)
            hold_req = 1'b1;
        start = bytes_sent;
        // the pressure phase needs a good descriptor so that results pile up
        send_descriptor(!pressure && $urandom_range(0, 9) == 0);
        while (bytes_sent - start < PHASE_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75 || pressure)
                send_frame();
            else if (pick < 85)
                send_byte(8'($urandom()), 1'b0, ROW_MODEL, NO_RESULT);
            else if (pick < 92)
                send_descriptor($urandom_range(0, 2) == 0);
            else if (pick < 96)
            begin
                // cut-off frame: following bytes land in its payload
                send_byte(SYNC_BYTE, 1'b0, ROW_MODEL, NO_RESULT);
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom()), 1'b0, ROW_MODEL, NO_RESULT);
            end
            else
                repeat (7)
                    send_byte(8'($urandom()), $urandom_range(0, 3) == 0, ROW_MODEL, NO_RESULT);
        end
        // leave the parser with a good descriptor for the next phase
        send_descriptor(1'b0);
    endtask

    // receiver: stall pattern of its own, plus one long hold-off on request
    int unsigned stall_left  = 0;
    int unsigned hold_left   = 0;
    int unsigned stall_pct   = 0;
    int unsigned pattern_age = 0;

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (pattern_age == 0)
        begin
            pattern_age = $urandom_range(32, 160);
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 50;
            endcase
        end
        pattern_age--;
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready   = 1'b0;
        end
        else
            m_tready = 1'b1;
    end

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (scan_results_due.size() == 0)
                report_mismatch("result transfer with none pending", m_tdata, 0);
            else
            begin
                want = scan_results_due.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata[0] != want.ok)
                    report_mismatch("descriptor_ok", m_tdata[0], want.ok);
                if (m_tdata[15:1] != want.angle)
                    report_mismatch("angle_q6", m_tdata[15:1], want.angle);
                if (m_tdata[31:16] != want.distance)
                    report_mismatch("distance_q2", m_tdata[31:16], want.distance);
            end
        end
    end

    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_window();

        for (int i = 0; i < N_ROWS; i++)
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].restart,
                      DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].res);

        run_phase(15'd0, 15'd0, 1'b0);
        run_phase(WINDOW_HIGH_RST, WINDOW_HIGH_RST, 1'b0);
        run_phase(15'd1000, WRAP_LIMIT_Q6, 1'b0);
        run_phase(15'd5000, 15'd100, 1'b0);
        run_phase(WINDOW_LOW_RST, WINDOW_HIGH_RST, 1'b1);
        run_phase(15'd6000, 15'd12000, 1'b0);
        run_phase(15'($urandom_range(0, 23039)), 15'($urandom_range(0, 23039)), 1'b0);
        run_phase(15'($urandom_range(0, 3000)), 15'($urandom_range(0, 3000)), 1'b0);

        wait_idle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
